@@ design/rsh_pkg.sv @@
`timescale 1ns / 1ps
package rsh_pkg;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int DIR_W     = 18;
    localparam int RAD_IN_W  = 31;
    localparam int L_W       = COORD_W + 1;
    localparam int DOT_W     = L_W + DIR_W + 2;
    localparam int TCA_W     = DOT_W - FRAC_BITS;
    localparam int LSQ_W     = 2 * L_W + 2;
    localparam int TSQ_W     = 2 * TCA_W;
    localparam int R2_W      = 2 * RAD_IN_W;
    localparam int ROOT_W    = RAD_IN_W;
    localparam int T_W       = TCA_W + 1;
    localparam int PROD_W    = T_W + 1 + DIR_W;
    localparam int SUM_W     = PROD_W + 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIR_W-1:0]   t_dir;

    // data that rides alongside the square root pipeline
    typedef struct packed {
        logic             hit;
        logic [TCA_W-1:0] tca;
        t_dir             dx;
        t_dir             dy;
        t_dir             dz;
        t_coord           ox;
        t_coord           oy;
        t_coord           oz;
    } t_side;
endpackage

@@ design/rsh_front.sv @@
`timescale 1ns / 1ps
module rsh_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  rsh_pkg::t_coord          i_ox,
    input  rsh_pkg::t_coord          i_oy,
    input  rsh_pkg::t_coord          i_oz,
    input  rsh_pkg::t_dir            i_dx,
    input  rsh_pkg::t_dir            i_dy,
    input  rsh_pkg::t_dir            i_dz,
    input  rsh_pkg::t_coord          i_cx,
    input  rsh_pkg::t_coord          i_cy,
    input  rsh_pkg::t_coord          i_cz,
    input  logic [rsh_pkg::RAD_IN_W-1:0] i_rad,
    output logic                     o_valid,
    output logic [rsh_pkg::R2_W-1:0] o_rad,
    output rsh_pkg::t_side           o_side
);
    import rsh_pkg::*;

    // stage 1: L = center - origin
    logic                    r_v1;
    logic signed [L_W-1:0]   r_l1 [3];
    t_side                   r_s1;
    logic [RAD_IN_W-1:0]     r_r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= i_valid;
        r_l1[0] <= L_W'(i_cx) - L_W'(i_ox);
        r_l1[1] <= L_W'(i_cy) - L_W'(i_oy);
        r_l1[2] <= L_W'(i_cz) - L_W'(i_oz);
        r_s1 <= '{hit: 1'b0, tca: '0, dx: i_dx, dy: i_dy, dz: i_dz,
                  ox: i_ox, oy: i_oy, oz: i_oz};
        r_r1 <= i_rad;
    end

    // stage 2: products
    logic                          r_v2;
    logic signed [L_W+DIR_W-1:0]   r_pd [3];
    logic signed [2*L_W-1:0]       r_pl [3];
    logic [R2_W-1:0]               r_r2;
    t_side                         r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_pd[0] <= r_l1[0] * L_W'(r_s1.dx);
        r_pd[1] <= r_l1[1] * L_W'(r_s1.dy);
        r_pd[2] <= r_l1[2] * L_W'(r_s1.dz);
        for (int i = 0; i < 3; i++) begin
            r_pl[i] <= r_l1[i] * r_l1[i];
        end
        r_r2 <= R2_W'(r_r1) * R2_W'(r_r1);
        r_s2 <= r_s1;
    end

    // stage 3: dot product and |L|^2
    logic                     r_v3;
    logic signed [DOT_W-1:0]  r_dot;
    logic [LSQ_W-1:0]         r_lsq;
    logic [R2_W-1:0]          r_r3;
    t_side                    r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_dot <= DOT_W'(r_pd[0]) + DOT_W'(r_pd[1]) + DOT_W'(r_pd[2]);
        r_lsq <= LSQ_W'($unsigned(r_pl[0])) + LSQ_W'($unsigned(r_pl[1]))
               + LSQ_W'($unsigned(r_pl[2]));
        r_r3 <= r_r2;
        r_s3 <= r_s2;
    end

    // stage 4: tca, its square, behind-the-origin test
    logic              r_v4;
    logic [TSQ_W-1:0]  r_tsq;
    logic [LSQ_W-1:0]  r_lsq4;
    logic [R2_W-1:0]   r_r4;
    t_side             r_s4;
    logic [TCA_W-1:0]  w_tca;

    assign w_tca = r_dot[DOT_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
        r_tsq  <= TSQ_W'(w_tca) * TSQ_W'(w_tca);
        r_lsq4 <= r_lsq;
        r_r4   <= r_r3;
        r_s4   <= '{hit: ~r_dot[DOT_W-1], tca: w_tca,
                    dx: r_s3.dx, dy: r_s3.dy, dz: r_s3.dz,
                    ox: r_s3.ox, oy: r_s3.oy, oz: r_s3.oz};
    end

    // stage 5: perpendicular distance against radius
    logic [TSQ_W-1:0] w_lsq;
    logic [TSQ_W-1:0] w_d2;

    assign w_lsq = TSQ_W'(r_lsq4);
    assign w_d2  = (r_tsq >= w_lsq) ? '0 : (w_lsq - r_tsq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_v4;
        o_rad  <= r_r4 - w_d2[R2_W-1:0];
        o_side <= '{hit: r_s4.hit && (w_d2 <= TSQ_W'(r_r4)), tca: r_s4.tca,
                    dx: r_s4.dx, dy: r_s4.dy, dz: r_s4.dz,
                    ox: r_s4.ox, oy: r_s4.oy, oz: r_s4.oz};
    end
endmodule

@@ design/rsh_sqrt.sv @@
`timescale 1ns / 1ps
module rsh_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [rsh_pkg::R2_W-1:0]   i_rad,
    input  rsh_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic [rsh_pkg::ROOT_W-1:0] o_root,
    output rsh_pkg::t_side             o_side
);
    import rsh_pkg::*;

    localparam int W = R2_W + 1;

    // one restoring square root step per stage, two radicand bits each
    logic         r_v   [ROOT_W];
    logic [W-1:0] r_rem [ROOT_W];
    logic [W-1:0] r_res [ROOT_W];
    t_side        r_sd  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (2 * (ROOT_W - 1 - k));
        logic         w_v;
        logic [W-1:0] w_rem;
        logic [W-1:0] w_res;
        t_side        w_sd;
        logic [W-1:0] w_try;

        // first step takes the radicand, later steps chain on
        if (k == 0) begin : g_head
            assign w_v   = i_valid;
            assign w_rem = W'(i_rad);
            assign w_res = '0;
            assign w_sd  = i_side;
        end else begin : g_link
            assign w_v   = r_v[k-1];
            assign w_rem = r_rem[k-1];
            assign w_res = r_res[k-1];
            assign w_sd  = r_sd[k-1];
        end

        assign w_try = w_res + BIT;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k] <= 1'b0;
            else          r_v[k] <= w_v;
            if (w_rem >= w_try) begin
                r_rem[k] <= w_rem - w_try;
                r_res[k] <= (w_res >> 1) + BIT;
            end else begin
                r_rem[k] <= w_rem;
                r_res[k] <= w_res >> 1;
            end
            r_sd[k] <= w_sd;
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_res[ROOT_W-1][ROOT_W-1:0];
    assign o_side  = r_sd[ROOT_W-1];
endmodule

@@ design/rsh_back.sv @@
`timescale 1ns / 1ps
module rsh_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [rsh_pkg::ROOT_W-1:0] i_root,
    input  rsh_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic                       o_hit,
    output rsh_pkg::t_coord            o_hit_x,
    output rsh_pkg::t_coord            o_hit_y,
    output rsh_pkg::t_coord            o_hit_z
);
    import rsh_pkg::*;

    // stage A: nearest non-negative distance along the ray
    logic           r_va;
    logic [T_W-1:0] r_t;
    t_side          r_sa;
    logic [T_W-1:0] w_tca;
    logic [T_W-1:0] w_thc;

    assign w_tca = T_W'(i_side.tca);
    assign w_thc = T_W'(i_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else          r_va <= i_valid;
        r_t  <= (w_tca >= w_thc) ? (w_tca - w_thc) : (w_tca + w_thc);
        r_sa <= i_side;
    end

    // stage B: t * direction
    logic                       r_vb;
    logic signed [PROD_W-1:0]   r_p [3];
    t_side                      r_sb;
    logic signed [PROD_W-1:0]   w_t;

    assign w_t = PROD_W'(r_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else          r_vb <= r_va;
        r_p[0] <= w_t * PROD_W'(r_sa.dx);
        r_p[1] <= w_t * PROD_W'(r_sa.dy);
        r_p[2] <= w_t * PROD_W'(r_sa.dz);
        r_sb   <= r_sa;
    end

    // stage C: origin + floor(p / 2^F), saturated; zeros on a miss
    logic signed [SUM_W-1:0] w_sum [3];
    t_coord                  w_sat [3];
    t_coord                  w_org [3];

    assign w_org[0] = r_sb.ox;
    assign w_org[1] = r_sb.oy;
    assign w_org[2] = r_sb.oz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = SUM_W'(w_org[i]) + SUM_W'(r_p[i] >>> FRAC_BITS);
            if (&w_sum[i][SUM_W-1:COORD_W-1] || ~|w_sum[i][SUM_W-1:COORD_W-1])
                w_sat[i] = w_sum[i][COORD_W-1:0];
            else if (w_sum[i][SUM_W-1])
                w_sat[i] = {1'b1, {(COORD_W-1){1'b0}}};
            else
                w_sat[i] = {1'b0, {(COORD_W-1){1'b1}}};
            if (!r_sb.hit) w_sat[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_vb;
        o_hit   <= r_sb.hit;
        o_hit_x <= w_sat[0];
        o_hit_y <= w_sat[1];
        o_hit_z <= w_sat[2];
    end
endmodule

@@ design/ray_sphere_hit_point.sv @@
`timescale 1ns / 1ps
// Ray / sphere intersection, geometric method, signed Q16.16 fixed point.
// Input: a ray (origin, unit direction) and a sphere (center, radius) are
// taken as one word at a rising edge with start high and busy low. busy is
// always low, so a new word may be issued on every clock.
// Output: o_valid strobes for one cycle with o_hit and the hit point
// o_hit_x/y/z (saturated; all zero on a miss). The receiver cannot stall.
// Pipeline: 39 register stages: five front stages (difference, products,
// sums, tca^2, distance compare), 31 square root stages (one result bit
// per stage), three back stages.
// Throughput: one word per cycle, fixed by the fully pipelined root unit.
// Results leave in the order words came in.
// Reset (i_rst_n low, synchronous) clears only the valid bits in flight;
// words in the pipe at reset are dropped.
module ray_sphere_hit_point (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  rsh_pkg::t_coord              i_ray_origin_x,
    input  rsh_pkg::t_coord              i_ray_origin_y,
    input  rsh_pkg::t_coord              i_ray_origin_z,
    input  rsh_pkg::t_dir                i_ray_dir_x,
    input  rsh_pkg::t_dir                i_ray_dir_y,
    input  rsh_pkg::t_dir                i_ray_dir_z,
    input  rsh_pkg::t_coord              i_sphere_center_x,
    input  rsh_pkg::t_coord              i_sphere_center_y,
    input  rsh_pkg::t_coord              i_sphere_center_z,
    input  logic [rsh_pkg::RAD_IN_W-1:0] i_sphere_radius,
    output logic                         o_valid,
    output logic                         o_hit,
    output rsh_pkg::t_coord              o_hit_x,
    output rsh_pkg::t_coord              o_hit_y,
    output rsh_pkg::t_coord              o_hit_z
);
    import rsh_pkg::*;

    logic             w_fv;
    logic [R2_W-1:0]  w_rad;
    t_side            w_fs;
    logic             w_sv;
    logic [ROOT_W-1:0] w_root;
    t_side            w_ss;

    assign busy = 1'b0;

    rsh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_ox    (i_ray_origin_x),
        .i_oy    (i_ray_origin_y),
        .i_oz    (i_ray_origin_z),
        .i_dx    (i_ray_dir_x),
        .i_dy    (i_ray_dir_y),
        .i_dz    (i_ray_dir_z),
        .i_cx    (i_sphere_center_x),
        .i_cy    (i_sphere_center_y),
        .i_cz    (i_sphere_center_z),
        .i_rad   (i_sphere_radius),
        .o_valid (w_fv),
        .o_rad   (w_rad),
        .o_side  (w_fs)
    );

    rsh_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .i_rad   (w_rad),
        .i_side  (w_fs),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_side  (w_ss)
    );

    rsh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sv),
        .i_root  (w_root),
        .i_side  (w_ss),
        .o_valid (o_valid),
        .o_hit   (o_hit),
        .o_hit_x (o_hit_x),
        .o_hit_y (o_hit_y),
        .o_hit_z (o_hit_z)
    );
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import rsh_pkg::*;

    localparam int LATENCY = 39;

    // one expected result word
    typedef struct {
        logic   hit;
        t_coord x;
        t_coord y;
        t_coord z;
    } hit_word_t;

    // geometric ray / sphere prediction, exact wide integer math
    function automatic hit_word_t predict_hit(
        t_coord ox, t_coord oy, t_coord oz, t_dir dx, t_dir dy, t_dir dz,
        t_coord cx, t_coord cy, t_coord cz, logic [RAD_IN_W-1:0] rad);
        logic signed [63:0] org [3];
        logic signed [63:0] dir [3];
        logic signed [63:0] lv [3];
        logic signed [63:0] dot;
        logic [127:0] lsq, tsq, d2, r2, rem;
        logic [63:0] tca, thc, t, root, bitv, v;
        logic signed [127:0] prod, pt;
        hit_word_t res;
        res = '{1'b0, '0, '0, '0};
        org[0] = ox; org[1] = oy; org[2] = oz;
        dir[0] = dx; dir[1] = dy; dir[2] = dz;
        lv[0] = 64'(cx) - org[0];
        lv[1] = 64'(cy) - org[1];
        lv[2] = 64'(cz) - org[2];
        dot = 0;
        lsq = 0;
        for (int i = 0; i < 3; i++) begin
            dot += lv[i] * dir[i];
            lsq += 128'(lv[i]) * 128'(lv[i]);
        end
        if (dot < 0) return res;
        tca = 64'(dot) >> FRAC_BITS;
        tsq = 128'(tca) * 128'(tca);
        d2 = (tsq >= lsq) ? 128'd0 : lsq - tsq;
        r2 = 128'(rad) * 128'(rad);
        if (r2 < d2) return res;
        rem = r2 - d2;
        v = rem[63:0];
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        thc = root;
        t = (tca >= thc) ? tca - thc : tca + thc;
        res.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            prod = 128'(signed'({1'b0, t})) * 128'(dir[i]);
            // arithmetic shift floors toward minus infinity
            pt = 128'(org[i]) + (prod >>> FRAC_BITS);
            if (pt > 128'sd2147483647) pt = 128'sd2147483647;
            if (pt < -128'sd2147483648) pt = -128'sd2147483648;
            if (i == 0) res.x = pt[31:0];
            else if (i == 1) res.y = pt[31:0];
            else res.z = pt[31:0];
        end
        return res;
    endfunction

    // in-order store of predicted hit words
    class hit_scoreboard;
        hit_word_t pending[$];
        int errors = 0;

        function void note_word(hit_word_t w);
            pending.push_back(w);
        endfunction

        function void check_word(hit_word_t got);
            hit_word_t exp_w;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word hit=%0b", got.hit);
                return;
            end
            exp_w = pending.pop_front();
            if (got.hit !== exp_w.hit || got.x !== exp_w.x || got.y !== exp_w.y
                || got.z !== exp_w.z) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp hit=%0b %h %h %h got hit=%0b %h %h %h",
                             exp_w.hit, exp_w.x, exp_w.y, exp_w.z,
                             got.hit, got.x, got.y, got.z);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_coord i_ray_origin_x = '0, i_ray_origin_y = '0, i_ray_origin_z = '0;
    t_dir i_ray_dir_x = '0, i_ray_dir_y = '0, i_ray_dir_z = '0;
    t_coord i_sphere_center_x = '0, i_sphere_center_y = '0, i_sphere_center_z = '0;
    logic [RAD_IN_W-1:0] i_sphere_radius = '0;
    logic o_valid, o_hit;
    t_coord o_hit_x, o_hit_y, o_hit_z;

    hit_scoreboard sb = new();

    always #6 i_clk = ~i_clk;

    ray_sphere_hit_point dut (.*);

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            sb.check_word('{o_hit, o_hit_x, o_hit_y, o_hit_z});
    end

    // issue one ray word, hold until accepted, then idle for gap cycles
    task automatic send_ray(t_coord ox, t_coord oy, t_coord oz, t_dir dx, t_dir dy,
                            t_dir dz, t_coord cx, t_coord cy, t_coord cz,
                            logic [RAD_IN_W-1:0] rad, int gap);
        start <= 1'b1;
        i_ray_origin_x <= ox; i_ray_origin_y <= oy; i_ray_origin_z <= oz;
        i_ray_dir_x <= dx; i_ray_dir_y <= dy; i_ray_dir_z <= dz;
        i_sphere_center_x <= cx; i_sphere_center_y <= cy; i_sphere_center_z <= cz;
        i_sphere_radius <= rad;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_word(predict_hit(ox, oy, oz, dx, dy, dz, cx, cy, cz, rad));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_dir rand_dir();
        case ($urandom_range(0, 4))
            0: return t_dir'(65536);
            1: return t_dir'(-65536);
            2: return t_dir'($urandom);
            default: return t_dir'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic t_coord rand_coord(bit wide);
        if (wide) return t_coord'($urandom);
        return t_coord'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    endfunction

    function automatic int rand_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    endfunction

    initial begin
        t_coord ox, oy, oz, cx, cy, cz;
        t_dir dx, dy, dz;
        logic [RAD_IN_W-1:0] rad;
        int k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: head-on hit, miss behind, tangent, offset miss, inside, extremes
        send_ray(0, 0, 0, 65536, 0, 0, 10 << 16, 0, 0, 2 << 16, 0);
        send_ray(0, 0, 0, -65536, 0, 0, 10 << 16, 0, 0, 2 << 16, 0);
        send_ray(0, 0, 0, 65536, 0, 0, 10 << 16, 2 << 16, 0, 2 << 16, 1);
        send_ray(0, 0, 0, 65536, 0, 0, 10 << 16, 3 << 16, 0, 2 << 16, 0);
        send_ray(0, 0, 0, 0, 65536, 0, 0, 1 << 16, 0, 5 << 16, 0);
        send_ray(0, 0, 0, 0, 0, -65536, 0, 0, 1 << 16, 5 << 16, 2);
        send_ray(0, 0, 0, 0, 0, 65536, 0, 0, 0, 5 << 16, 0);
        send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 65536, 65536, 65536,
                 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff, 0);
        send_ray(32'sh80000000, 32'sh80000000, 32'sh80000000, 65536, 65536, 65536,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 0);
        send_ray(32'sh7fff0000, 0, 0, 65536, 0, 0, 32'sh7fffffff, 0, 0, 31'h7fffffff, 3);
        send_ray(32'sh80000000, 0, 0, -65536, 0, 0, 32'sh80000000, 0, 0, 31'h7fffffff, 0);
        send_ray(0, 0, 0, t_dir'(18'h1ffff), t_dir'(18'h1ffff), t_dir'(18'h20000),
                 1 << 20, 1 << 20, 0, 31'h7fffffff, 0);
        send_ray(0, 0, 0, t_dir'(18'h20000), 0, 0, -(1 << 20), 0, 0, 1 << 16, 0);
        send_ray(100, 200, 300, 46341, 46341, 0, 5 << 16, 5 << 16, 0, 0, 4);
        send_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // hold off until the pipe drains
        start <= 1'b0;
        k = 0;
        while (sb.pending.size() != 0 && k < 1000) begin
            @(posedge i_clk);
            k++;
        end

        // random: mostly rays aimed near the sphere, some wide noise
        for (int n = 0; n < 935; n++) begin
            bit wide;
            wide = ($urandom_range(0, 9) == 0);
            ox = rand_coord(wide); oy = rand_coord(wide); oz = rand_coord(wide);
            dx = rand_dir(); dy = rand_dir(); dz = rand_dir();
            if (!wide && $urandom_range(0, 2) != 0) begin
                // place the center a random distance along the ray, with offset
                k = $urandom_range(0, 255);
                cx = ox + ((k * dx) >>> 0) + t_coord'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                cy = oy + ((k * dy) >>> 0) + t_coord'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                cz = oz + ((k * dz) >>> 0) + t_coord'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            end else begin
                cx = rand_coord(wide); cy = rand_coord(wide); cz = rand_coord(wide);
            end
            rad = wide ? 31'($urandom) : 31'($urandom_range(0, 32'h0040_0000));
            send_ray(ox, oy, oz, dx, dy, dz, cx, cy, cz, rad, rand_gap());
        end
        start <= 1'b0;

        k = 0;
        while (sb.pending.size() != 0 && k < 1000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end
endmodule

@@ files.f @@
design/rsh_pkg.sv
design/rsh_front.sv
design/rsh_sqrt.sv
design/rsh_back.sv
design/ray_sphere_hit_point.sv
dv/tb.sv
